// ----- src/tmq_pkg.sv -----
// Shared types and constants for the typed message queue.
// Holds request and status codes, the sequencer state type and the default sizes.
// No dependencies.
package tmq_pkg;

  localparam int DEPTH_DEF        = 16;
  localparam int PREFIX_BYTES_DEF = 8;

  localparam int IDX_W     = 8;
  localparam int CAP_LG_W  = 3;
  localparam int KIND_W    = 2;
  localparam int TYPE_W    = 8;
  localparam int HANDLE_W  = 32;
  localparam int LEN_W     = 16;
  localparam int BYTES_W   = 64;
  localparam int SEL_LEN_W = 4;
  localparam int STATUS_W  = 2;

  localparam logic [CAP_LG_W-1:0] CAP_LG_RESET = 3'd4;

  localparam logic [KIND_W-1:0] KIND_PUSH = 2'd0;
  localparam logic [KIND_W-1:0] KIND_POP  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_GET  = 2'd2;

  localparam logic [STATUS_W-1:0] STAT_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_MISS = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_POP,
    S_SCAN,
    S_SHIFT,
    S_DONE
  } state_t;

endpackage

// ----- src/tmq_mem.sv -----
// Entry storage for the typed message queue: one write port, one read port.
// Read data is registered. Depends on tmq_pkg for the default depth.
module tmq_mem
  import tmq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF,
  parameter int WIDTH = 8,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ----- src/tmq_match.sv -----
// Compare unit: checks one stored entry against the type and payload prefix of a get.
// Depends on tmq_pkg for field widths.
module tmq_match
  import tmq_pkg::*;
#(
  parameter int PREFIX_BYTES = PREFIX_BYTES_DEF
) (
  input  logic [TYPE_W-1:0]         entry_type,
  input  logic [LEN_W-1:0]          entry_len,
  input  logic [PREFIX_BYTES*8-1:0] entry_head,
  input  logic [TYPE_W-1:0]         want_type,
  input  logic [PREFIX_BYTES*8-1:0] sel,
  input  logic [SEL_LEN_W-1:0]      sel_len,
  output logic                      hit
);

  logic [PREFIX_BYTES-1:0] byte_ok;

  always_comb begin
    for (int i = 0; i < PREFIX_BYTES; i++) begin
      byte_ok[i] = (32'(i) >= 32'(sel_len)) || (entry_head[i*8 +: 8] == sel[i*8 +: 8]);
    end
  end

  always_comb begin
    if (entry_type != want_type) begin
      hit = 1'b0;
    end else if (sel_len == '0) begin
      hit = 1'b1;
    end else if (LEN_W'(sel_len) > entry_len) begin
      hit = 1'b0;
    end else begin
      hit = &byte_ok;
    end
  end

endmodule

// ----- src/typed_message_queue_selective_get_core.sv -----
// Top level of the typed message queue with selective get.
// Holds the request sequencer and indices; uses tmq_pkg, tmq_mem and tmq_match.
//
// Usage:
//   Requests enter on in_valid/in_ready, one beat per request; every request
//   returns exactly one result beat on out_valid/out_ready.
//   Push appends an entry (status full when at capacity), pop removes the head,
//   get removes the oldest entry of the wanted type whose stored payload prefix
//   starts with the selector.
//   Push, empty pop and unknown kind go straight to the result state; pop
//   first reads the head entry; get scans from the head in queue order until
//   the first match or the last entry, and a match past the head then moves
//   each younger entry down one slot. The single memory read port feeds the
//   compare unit one entry per cycle.
//   A new request can be accepted in the cycle in which out_valid rises; a
//   stalled receiver holds the output register, and the block then finishes
//   at most one more request before it waits.
//   cfg_wen writes capacity_log2 and empties the queue; write only while idle.
//   Reset empties the queue, sets capacity_log2 to 4 and drops any pending
//   result; entry storage is not cleared.
module typed_message_queue_selective_get_core
  import tmq_pkg::*;
#(
  parameter int DEPTH        = DEPTH_DEF,
  parameter int PREFIX_BYTES = PREFIX_BYTES_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wen,
  input  logic [CAP_LG_W-1:0]  cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [KIND_W-1:0]    kind,
  input  logic [TYPE_W-1:0]    msg_type,
  input  logic [HANDLE_W-1:0]  buffer_handle,
  input  logic [LEN_W-1:0]     payload_len,
  input  logic [BYTES_W-1:0]   head_bytes,
  input  logic [BYTES_W-1:0]   selector_bytes,
  input  logic [SEL_LEN_W-1:0] selector_len,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [STATUS_W-1:0]  status,
  output logic [TYPE_W-1:0]    out_type,
  output logic [HANDLE_W-1:0]  out_handle,
  output logic [LEN_W-1:0]     out_len
);

  localparam int AW     = $clog2(DEPTH);
  localparam int MAX_LG = $clog2(DEPTH + 1) - 1;
  localparam int HEAD_W = PREFIX_BYTES * 8;
  localparam int ENT_W  = TYPE_W + HANDLE_W + LEN_W + HEAD_W;

  state_t state, state_next;

  logic [CAP_LG_W-1:0] cap_lg;
  logic [IDX_W-1:0]    ri;
  logic [IDX_W-1:0]    wi;
  logic [IDX_W-1:0]    k;
  logic [IDX_W-1:0]    s;
  logic [IDX_W-1:0]    dst;
  logic                pend;

  logic [TYPE_W-1:0]    req_type;
  logic [HEAD_W-1:0]    req_sel;
  logic [SEL_LEN_W-1:0] req_sel_len;

  logic [STATUS_W-1:0] res_status;
  logic [TYPE_W-1:0]   res_type;
  logic [HANDLE_W-1:0] res_handle;
  logic [LEN_W-1:0]    res_len;

  logic [CAP_LG_W-1:0] eff_lg;
  logic [IDX_W-1:0]    cap;
  logic [IDX_W-1:0]    mask8;
  logic [AW-1:0]       mask_aw;
  logic [IDX_W-1:0]    count;
  logic                accept;
  logic                out_free;
  logic                hit;

  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [ENT_W-1:0] mem_wdata;
  logic [AW-1:0]    mem_raddr;
  logic [ENT_W-1:0] mem_rdata;

  logic [TYPE_W-1:0]   rd_type;
  logic [HANDLE_W-1:0] rd_handle;
  logic [LEN_W-1:0]    rd_len;
  logic [HEAD_W-1:0]   rd_head;

  function automatic logic [AW-1:0] slot_of(input logic [IDX_W-1:0] idx,
                                            input logic [AW-1:0] msk);
    return idx[AW-1:0] & msk;
  endfunction

  assign eff_lg   = (cap_lg > CAP_LG_W'(MAX_LG)) ? CAP_LG_W'(MAX_LG) : cap_lg;
  assign cap      = IDX_W'(1) << eff_lg;
  assign mask8    = cap - IDX_W'(1);
  assign mask_aw  = mask8[AW-1:0];
  assign count    = wi - ri;
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  assign rd_type   = mem_rdata[ENT_W-1 -: TYPE_W];
  assign rd_handle = mem_rdata[HANDLE_W+LEN_W+HEAD_W-1 -: HANDLE_W];
  assign rd_len    = mem_rdata[LEN_W+HEAD_W-1 -: LEN_W];
  assign rd_head   = mem_rdata[HEAD_W-1:0];

  tmq_mem #(
    .DEPTH (DEPTH),
    .WIDTH (ENT_W),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  tmq_match #(
    .PREFIX_BYTES (PREFIX_BYTES)
  ) u_match (
    .entry_type (rd_type),
    .entry_len  (rd_len),
    .entry_head (rd_head),
    .want_type  (req_type),
    .sel        (req_sel),
    .sel_len    (req_sel_len),
    .hit        (hit)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = slot_of(wi, mask_aw);
    mem_wdata  = {msg_type, buffer_handle, payload_len, head_bytes[HEAD_W-1:0]};
    mem_raddr  = slot_of(ri, mask_aw);
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (accept) begin
          state_next = S_DONE;
          if (kind == KIND_PUSH && count < cap) begin
            mem_we = 1'b1;
          end else if (kind == KIND_POP && count != '0) begin
            state_next = S_POP;
          end else if (kind == KIND_GET) begin
            state_next = S_SCAN;
          end
        end
      end
      S_POP: begin
        state_next = S_DONE;
      end
      S_SCAN: begin
        mem_raddr = slot_of(ri + k, mask_aw);
        if (pend && hit) begin
          state_next = (k == IDX_W'(1)) ? S_DONE : S_SHIFT;
        end else if (k == count) begin
          state_next = S_DONE;
        end
      end
      S_SHIFT: begin
        mem_raddr = slot_of(s, mask_aw);
        mem_we    = pend;
        mem_waddr = slot_of(dst, mask_aw);
        mem_wdata = mem_rdata;
        if (s == wi) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cap_lg    <= CAP_LG_RESET;
      ri        <= '0;
      wi        <= '0;
      k         <= '0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (cfg_wen) begin
            cap_lg <= cfg_wdata;
            ri     <= '0;
            wi     <= '0;
          end
          if (accept) begin
            k    <= '0;
            pend <= 1'b0;
            if (kind == KIND_PUSH && count < cap && !cfg_wen) begin
              wi <= wi + IDX_W'(1);
            end
          end
        end
        S_POP: begin
          ri <= ri + IDX_W'(1);
        end
        S_SCAN: begin
          if (pend && hit) begin
            pend <= 1'b0;
            if (k == IDX_W'(1)) begin
              ri <= ri + IDX_W'(1);
            end
          end else if (k != count) begin
            k    <= k + IDX_W'(1);
            pend <= 1'b1;
          end
        end
        S_SHIFT: begin
          if (s == wi) begin
            wi <= wi - IDX_W'(1);
          end else begin
            pend <= 1'b1;
          end
        end
        S_DONE: begin
        end
        default: begin
        end
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          req_type    <= msg_type;
          req_sel     <= selector_bytes[HEAD_W-1:0];
          req_sel_len <= selector_len;
          res_type    <= '0;
          res_handle  <= '0;
          res_len     <= '0;
          res_status  <= (kind != KIND_PUSH) ? STAT_MISS :
                         (count < cap) ? STAT_OK : STAT_FULL;
        end
      end
      S_POP: begin
        res_status <= STAT_OK;
        res_type   <= rd_type;
        res_handle <= rd_handle;
        res_len    <= rd_len;
      end
      S_SCAN: begin
        if (pend && hit) begin
          res_status <= STAT_OK;
          res_handle <= rd_handle;
          res_len    <= rd_len;
          s          <= ri + k;
        end
      end
      S_SHIFT: begin
        if (s != wi) begin
          dst <= s - IDX_W'(1);
          s   <= s + IDX_W'(1);
        end
      end
      S_DONE: begin
        if (out_free) begin
          status     <= res_status;
          out_type   <= res_type;
          out_handle <= res_handle;
          out_len    <= res_len;
        end
      end
      default: begin
      end
    endcase
  end

  a_count_le_cap: assert property (@(posedge clk) disable iff (rst)
    count <= cap)
    else $error("queue count exceeds capacity");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN |-> k <= count)
    else $error("scan position past queue count");

  a_shift_pops_tail: assert property (@(posedge clk) disable iff (rst)
    (state == S_SHIFT && state_next == S_DONE) |=> wi == $past(wi) - IDX_W'(1))
    else $error("compaction did not step write index back by one");

  a_done_holds: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && out_valid && !out_ready) |=> state == S_DONE)
    else $error("result dropped while receiver stalled");

endmodule

// ----- tb/tmq_checker.sv -----
`timescale 1ns / 1ps
// Result checker for typed_message_queue_selective_get_core: tracks the capacity register,
// keeps a private copy of the message queue and compares each result beat in order.
// Depends on tmq_pkg.
module tmq_checker
  import tmq_pkg::*;
#(
  parameter int DEPTH        = DEPTH_DEF,
  parameter int PREFIX_BYTES = PREFIX_BYTES_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wen,
  input  logic [CAP_LG_W-1:0]  cfg_wdata,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  logic [KIND_W-1:0]    kind,
  input  logic [TYPE_W-1:0]    msg_type,
  input  logic [HANDLE_W-1:0]  buffer_handle,
  input  logic [LEN_W-1:0]     payload_len,
  input  logic [BYTES_W-1:0]   head_bytes,
  input  logic [BYTES_W-1:0]   selector_bytes,
  input  logic [SEL_LEN_W-1:0] selector_len,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  logic [STATUS_W-1:0]  status,
  input  logic [TYPE_W-1:0]    out_type,
  input  logic [HANDLE_W-1:0]  out_handle,
  input  logic [LEN_W-1:0]     out_len,
  output int                   errors,
  output int                   outstanding
);

  typedef struct {
    logic [STATUS_W-1:0] status;
    logic [TYPE_W-1:0]   typ;
    logic [HANDLE_W-1:0] handle;
    logic [LEN_W-1:0]    len;
  } result_t;

  logic [CAP_LG_W-1:0] cap_lg = CAP_LG_RESET;
  logic [IDX_W-1:0]    rd_idx = '0;
  logic [IDX_W-1:0]    wr_idx = '0;
  logic [TYPE_W-1:0]   slot_type   [DEPTH];
  logic [HANDLE_W-1:0] slot_handle [DEPTH];
  logic [LEN_W-1:0]    slot_len    [DEPTH];
  logic [BYTES_W-1:0]  slot_head   [DEPTH];

  result_t awaited_results[$];
  result_t got;
  result_t want;
  int      mismatches = 0;
  int      waiting    = 0;

  assign errors      = mismatches;
  assign outstanding = waiting;

  function automatic int unsigned capacity_now();
    int unsigned c;
    int unsigned lg;
    c  = 1;
    lg = cap_lg;
    while (lg > 0 && c * 2 <= DEPTH) begin
      c = c * 2;
      lg--;
    end
    return c;
  endfunction

  function automatic bit prefix_hit(int unsigned slot, logic [TYPE_W-1:0] typ,
                                    logic [BYTES_W-1:0] sel, logic [SEL_LEN_W-1:0] sel_len);
    int unsigned        n;
    logic [BYTES_W-1:0] mask;
    if (slot_type[slot] != typ) return 1'b0;
    if (sel_len == 0) return 1'b1;
    if (sel_len > slot_len[slot]) return 1'b0;
    n    = (sel_len < PREFIX_BYTES) ? sel_len : PREFIX_BYTES;
    mask = '0;
    for (int b = 0; b < n; b++) mask[8*b +: 8] = 8'hFF;
    return ((sel ^ slot_head[slot]) & mask) == '0;
  endfunction

  function automatic result_t apply_request(logic [KIND_W-1:0] req_kind,
                                            logic [TYPE_W-1:0] typ,
                                            logic [HANDLE_W-1:0] handle,
                                            logic [LEN_W-1:0] len,
                                            logic [BYTES_W-1:0] head,
                                            logic [BYTES_W-1:0] sel,
                                            logic [SEL_LEN_W-1:0] sel_len);
    result_t          r;
    int unsigned      cap;
    int unsigned      msk;
    int unsigned      cnt;
    int unsigned      s;
    int unsigned      d;
    int unsigned      src;
    logic [IDX_W-1:0] fill;
    bit               hit;
    r.status = STAT_MISS;
    r.typ    = '0;
    r.handle = '0;
    r.len    = '0;
    cap  = capacity_now();
    msk  = cap - 1;
    fill = wr_idx - rd_idx;
    cnt  = fill;
    hit  = 1'b0;
    case (req_kind)
      KIND_PUSH: begin
        if (cnt >= cap) begin
          r.status = STAT_FULL;
        end else begin
          s = wr_idx & msk;
          slot_type[s]   = typ;
          slot_handle[s] = handle;
          slot_len[s]    = len;
          slot_head[s]   = head;
          wr_idx         = wr_idx + 1'b1;
          r.status       = STAT_OK;
        end
      end
      KIND_POP: begin
        if (cnt != 0) begin
          s = rd_idx & msk;
          r.typ    = slot_type[s];
          r.handle = slot_handle[s];
          r.len    = slot_len[s];
          rd_idx   = rd_idx + 1'b1;
          r.status = STAT_OK;
        end
      end
      KIND_GET: begin
        for (int k = 0; k < cnt && !hit; k++) begin
          s = (rd_idx + k) & msk;
          if (prefix_hit(s, typ, sel, sel_len)) begin
            r.handle = slot_handle[s];
            r.len    = slot_len[s];
            r.status = STAT_OK;
            if (k == 0) begin
              rd_idx = rd_idx + 1'b1;
            end else begin
              for (int m = k + 1; m < cnt; m++) begin
                d   = (rd_idx + m - 1) & msk;
                src = (rd_idx + m) & msk;
                slot_type[d]   = slot_type[src];
                slot_handle[d] = slot_handle[src];
                slot_len[d]    = slot_len[src];
                slot_head[d]   = slot_head[src];
              end
              wr_idx = wr_idx - 1'b1;
            end
            hit = 1'b1;
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
    if (exp_val !== act_val) begin
      $error("%s: expected %0h, got %0h", name, exp_val, act_val);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      cap_lg = CAP_LG_RESET;
      rd_idx = '0;
      wr_idx = '0;
      awaited_results.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (awaited_results.size() == 0) begin
          $error("result beat with no request waiting: status %0h handle %0h",
                 status, out_handle);
          mismatches++;
        end else begin
          want       = awaited_results.pop_front();
          got.status = status;
          got.typ    = out_type;
          got.handle = out_handle;
          got.len    = out_len;
          check_field("status", want.status, got.status);
          check_field("out_type", want.typ, got.typ);
          check_field("out_handle", want.handle, got.handle);
          check_field("out_len", want.len, got.len);
        end
      end
      if (cfg_wen) begin
        cap_lg = cfg_wdata;
        rd_idx = '0;
        wr_idx = '0;
      end
      if (in_valid && in_ready) begin
        awaited_results.push_back(apply_request(kind, msg_type, buffer_handle, payload_len,
                                                head_bytes, selector_bytes, selector_len));
      end
    end
    waiting = awaited_results.size();
  end

endmodule

// ----- tb/tb_typed_message_queue_selective_get_core.sv -----
`timescale 1ns / 1ps
// Top of the typed message queue testbench: clock, reset, directed and random requests,
// random stalls on both channels, and the verdict. Depends on tmq_pkg, tmq_checker and the core.
module tb_typed_message_queue_selective_get_core;
  import tmq_pkg::*;

  localparam logic [KIND_W-1:0] KIND_NONE = 2'd3;
  localparam int                ITEMS_PER_PHASE = 190;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_wen = 1'b0;
  logic [CAP_LG_W-1:0]  cfg_wdata = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [KIND_W-1:0]    kind = '0;
  logic [TYPE_W-1:0]    msg_type = '0;
  logic [HANDLE_W-1:0]  buffer_handle = '0;
  logic [LEN_W-1:0]     payload_len = '0;
  logic [BYTES_W-1:0]   head_bytes = '0;
  logic [BYTES_W-1:0]   selector_bytes = '0;
  logic [SEL_LEN_W-1:0] selector_len = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [STATUS_W-1:0]  status;
  logic [TYPE_W-1:0]    out_type;
  logic [HANDLE_W-1:0]  out_handle;
  logic [LEN_W-1:0]     out_len;

  int                   fail_count;
  int                   results_owed;
  bit                   src_quiet = 1'b0;
  bit                   sink_quiet = 1'b0;
  int unsigned          stall_left = 0;
  int unsigned          stall_draw;
  logic [BYTES_W-1:0]   head_pool [4];

  logic [CAP_LG_W-1:0]  phase_cap  [8] = '{3'd7, 3'd0, 3'd1, 3'd2, 3'd3, 3'd5, 3'd6, 3'd4};
  int unsigned          phase_push [8] = '{45, 35, 40, 50, 45, 55, 40, 60};

  typed_message_queue_selective_get_core uut (.*);

  tmq_checker chk (
    .*,
    .errors      (fail_count),
    .outstanding (results_owed)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    if (rst) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
    end else begin
      if ($urandom_range(0, 59) == 0) sink_quiet <= !sink_quiet;
      if (out_ready) begin
        if (out_valid) begin
          stall_draw = sink_quiet ? 0 : $urandom_range(0, 19);
          if (stall_draw != 0) begin
            out_ready  <= 1'b0;
            stall_left <= stall_draw - 1;
          end
        end
      end else if (stall_left == 0) begin
        out_ready <= 1'b1;
      end else begin
        stall_left <= stall_left - 1;
      end
    end
  end

  task automatic send(logic [KIND_W-1:0] k, logic [TYPE_W-1:0] t, logic [HANDLE_W-1:0] h,
                      logic [LEN_W-1:0] l, logic [BYTES_W-1:0] hb,
                      logic [BYTES_W-1:0] sb, logic [SEL_LEN_W-1:0] sl);
    int unsigned gap;
    if ($urandom_range(0, 39) == 0) src_quiet = !src_quiet;
    gap = src_quiet ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    kind           <= k;
    msg_type       <= t;
    buffer_handle  <= h;
    payload_len    <= l;
    head_bytes     <= hb;
    selector_bytes <= sb;
    selector_len   <= sl;
    in_valid       <= 1'b1;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain();
    do @(negedge clk); while (results_owed != 0);
  endtask

  task automatic set_capacity(logic [CAP_LG_W-1:0] lg);
    in_valid <= 1'b0;
    drain();
    @(posedge clk);
    cfg_wen   <= 1'b1;
    cfg_wdata <= lg;
    @(posedge clk);
    cfg_wen   <= 1'b0;
  endtask

  function automatic logic [TYPE_W-1:0] pick_type();
    if ($urandom_range(0, 3) != 0) return TYPE_W'($urandom_range(0, 3));
    return TYPE_W'($urandom_range(0, 255));
  endfunction

  function automatic logic [BYTES_W-1:0] pick_bytes();
    if ($urandom_range(0, 4) != 0) return head_pool[$urandom_range(0, 3)];
    return {$urandom, $urandom};
  endfunction

  task automatic random_item(int unsigned push_weight);
    int unsigned        roll;
    logic [KIND_W-1:0]  k;
    logic [LEN_W-1:0]   l;
    logic [BYTES_W-1:0] sel;
    logic [SEL_LEN_W-1:0] sl;
    roll = $urandom_range(0, 99);
    if (roll < push_weight) k = KIND_PUSH;
    else if (roll < push_weight + 20) k = KIND_POP;
    else if (roll < 96) k = KIND_GET;
    else k = KIND_NONE;
    l = ($urandom_range(0, 9) < 7) ? LEN_W'($urandom_range(0, 12))
                                   : LEN_W'($urandom_range(0, 65535));
    sel = pick_bytes();
    if ($urandom_range(0, 3) == 0) sel[8*$urandom_range(0, 7) +: 8] ^= 8'($urandom_range(1, 255));
    sl = ($urandom_range(0, 19) < 17) ? SEL_LEN_W'($urandom_range(0, 8))
                                      : SEL_LEN_W'($urandom_range(9, 15));
    send(k, pick_type(), $urandom, l, pick_bytes(), sel, sl);
  endtask

  initial begin
    #10_000_000;
    $display("tb_typed_message_queue_selective_get_core: errors");
    $finish;
  end

  initial begin
    head_pool[0] = {$urandom, $urandom};
    head_pool[1] = {$urandom, head_pool[0][31:0]};
    head_pool[2] = {8'(head_pool[0][63:56] ^ 8'h5A), head_pool[0][55:0]};
    head_pool[3] = {$urandom, $urandom};
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    send(KIND_POP, 8'h00, '0, '0, '0, '0, 4'd0);
    send(KIND_GET, 8'h05, '0, '0, '0, '1, 4'd8);
    send(KIND_NONE, 8'hFF, '1, '1, '1, '1, 4'hF);
    send(KIND_PUSH, 8'hFF, 32'hFFFF_FFFF, 16'hFFFF, '1, '0, 4'd0);
    send(KIND_PUSH, 8'h00, '0, '0, '0, '0, 4'd0);
    send(KIND_PUSH, 8'h05, 32'h600D_0001, 16'd3, 64'h0000_0000_00CC_BBAA, '0, 4'd0);
    send(KIND_PUSH, 8'h05, 32'h600D_0002, 16'd8, 64'h1122_3344_5566_7788, '0, 4'd0);
    send(KIND_GET, 8'h05, '0, '0, '0, 64'h1122_3344_5566_7788, 4'd9);
    send(KIND_GET, 8'h05, '0, '0, '0, 64'h0000_0000_0066_7788, 4'd3);
    send(KIND_GET, 8'h00, '0, '0, '0, '1, 4'd0);
    send(KIND_PUSH, 8'h05, 32'h600D_0003, 16'h0020, 64'h8877_6655_4433_2211, '0, 4'd0);
    send(KIND_GET, 8'h05, '0, '0, '0, 64'h8877_6655_4433_2211, 4'd15);
    send(KIND_GET, 8'hFF, '0, '0, '0, '1, 4'd8);
    send(KIND_POP, 8'h00, '0, '0, '0, '0, 4'd0);
    send(KIND_POP, 8'h00, '0, '0, '0, '0, 4'd0);
    set_capacity(3'd0);
    send(KIND_PUSH, 8'h5A, 32'hA5A5_A5A5, 16'h5A5A, 64'hA5A5_A5A5_A5A5_A5A5, '0, 4'd0);
    send(KIND_PUSH, 8'h5B, 32'h1234_5678, 16'h0001, '0, '0, 4'd0);
    send(KIND_GET, 8'h5A, '0, '0, '0, 64'h0123_4567_89AB_CDEF, 4'd0);
    send(KIND_POP, 8'h00, '0, '0, '0, '0, 4'd0);
    send(KIND_PUSH, 8'h01, 32'h0000_0101, 16'd8, 64'hDEAD_BEEF_CAFE_F00D, '0, 4'd0);
    send(KIND_GET, 8'h02, '0, '0, '0, 64'hDEAD_BEEF_CAFE_F00D, 4'd8);
    send(KIND_POP, 8'h00, '0, '0, '0, '0, 4'd0);

    for (int p = 0; p < 8; p++) begin
      set_capacity(phase_cap[p]);
      repeat (ITEMS_PER_PHASE) random_item(phase_push[p]);
    end
    in_valid <= 1'b0;
    drain();
    repeat (40) @(posedge clk);
    @(negedge clk);
    if (fail_count == 0) begin
      $display("tb_typed_message_queue_selective_get_core: clean");
    end else begin
      $display("tb_typed_message_queue_selective_get_core: errors");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
src/tmq_pkg.sv
src/tmq_mem.sv
src/tmq_match.sv
src/typed_message_queue_selective_get_core.sv
tb/tmq_checker.sv
tb/tb_typed_message_queue_selective_get_core.sv
